@@ design/cse_pkg.sv @@
// ----------------------------------------------------------------------------
// Counting sort engine package
// Shared widths, codes, state encoding and item types of the sort engine.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int unsigned VALUE_BITS = 12;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned BIN_DEPTH  = 1 << VALUE_BITS;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_PULL   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_INSERT,
    S_SCAN
  } state_e;

  typedef struct packed {
    op_e                           opcode;
    logic signed [VALUE_BITS-1:0]  value;
  } req_t;

  typedef struct packed {
    status_e                       status;
    logic signed [VALUE_BITS-1:0]  sorted_value;
    logic                          last_value;
  } rsp_t;

endpackage

@@ design/counting_sort_engine.sv @@
// ----------------------------------------------------------------------------
// Counting sort engine
// Histogram store of signed values that hands them back in ascending order.
// ----------------------------------------------------------------------------
// Usage: drive req_i and raise start_i; the item is taken at a rising edge
// where start_i is high and busy_o is low. busy_o stays high until the
// result has been produced. The result is marked by done_o, high for a
// single cycle, and stays on rsp_o until the next result; the receiver
// cannot hold it off. An insert item is one read-modify-write of the
// single-port bin memory: the bin is read as the item is accepted and
// written back in S_INSERT, which also raises done_o. A pull reads one
// bin per cycle, starting at the scan cursor, until it finds an occupied
// bin or reaches the upper scan bound; it reads at least 1 and at most
// 4096 bins. A refused insert or a pull on an empty store is answered
// as the item is accepted, with no bin read. The next item can be
// accepted in the cycle in which done_o is high. After reset the engine
// sweeps all 4096 bins to zero, one bin a cycle, with busy_o high.
// ----------------------------------------------------------------------------
module counting_sort_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  cse_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output cse_pkg::rsp_t rsp_o
);

  localparam int unsigned VB = cse_pkg::VALUE_BITS;
  localparam int unsigned CB = cse_pkg::COUNT_BITS;

  cse_pkg::state_e state_q, state_d;

  logic [CB-1:0] mem [cse_pkg::BIN_DEPTH];
  logic [CB-1:0] rdata_q;
  logic          rd_en, wr_en;
  logic [VB-1:0] rd_addr, wr_addr;
  logic [CB-1:0] wr_data;

  logic [VB-1:0] clr_q, clr_d;
  logic [VB-1:0] cursor_q, cursor_d;
  logic [VB-1:0] highest_q, highest_d;
  logic [VB-1:0] pos_q, pos_d;
  logic [CB-1:0] items_q, items_d;
  logic [VB-1:0] idx_q, idx_d;
  logic          done_q, done_d;
  cse_pkg::rsp_t rsp_q, rsp_d;

  logic [VB-1:0] in_idx;
  logic          accept;
  logic          store_full;

  // Values are held as biased indices: flipping the sign bit makes the
  // unsigned order of the index match the signed order of the value.
  assign in_idx     = {~req_i.value[VB-1], req_i.value[VB-2:0]};
  assign accept     = start_i && (state_q == cse_pkg::S_IDLE);
  assign store_full = (items_q == {CB{1'b1}});

  always_comb begin
    state_d = state_q;
    case (state_q)
      cse_pkg::S_CLEAR: begin
        if (clr_q == {VB{1'b1}}) state_d = cse_pkg::S_IDLE;
      end
      cse_pkg::S_IDLE: begin
        if (accept) begin
          if (req_i.opcode == cse_pkg::OP_INSERT) begin
            if (!store_full) state_d = cse_pkg::S_INSERT;
          end else if (items_q != '0) begin
            state_d = cse_pkg::S_SCAN;
          end
        end
      end
      cse_pkg::S_INSERT: begin
        state_d = cse_pkg::S_IDLE;
      end
      cse_pkg::S_SCAN: begin
        if (rdata_q != '0 || pos_q >= highest_q) state_d = cse_pkg::S_IDLE;
      end
      default: state_d = cse_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = cursor_q;
    wr_en     = 1'b0;
    wr_addr   = clr_q;
    wr_data   = '0;
    clr_d     = clr_q;
    cursor_d  = cursor_q;
    highest_d = highest_q;
    pos_d     = pos_q;
    items_d   = items_q;
    idx_d     = idx_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    case (state_q)
      cse_pkg::S_CLEAR: begin
        wr_en = 1'b1;
        clr_d = clr_q + 1'b1;
      end
      cse_pkg::S_IDLE: begin
        if (accept) begin
          if (req_i.opcode == cse_pkg::OP_INSERT) begin
            if (store_full) begin
              done_d = 1'b1;
              rsp_d  = '{status: cse_pkg::ST_FULL, sorted_value: '0, last_value: 1'b0};
            end else begin
              rd_en   = 1'b1;
              rd_addr = in_idx;
              idx_d   = in_idx;
            end
          end else if (items_q == '0) begin
            done_d = 1'b1;
            rsp_d  = '{status: cse_pkg::ST_EMPTY, sorted_value: '0, last_value: 1'b0};
          end else begin
            rd_en   = 1'b1;
            rd_addr = cursor_q;
            pos_d   = cursor_q;
          end
        end
      end
      cse_pkg::S_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = rdata_q + 1'b1;
        items_d = items_q + 1'b1;
        if (items_q == '0 || idx_q < cursor_q) cursor_d = idx_q;
        if (idx_q > highest_q) highest_d = idx_q;
        done_d  = 1'b1;
        rsp_d   = '{status: cse_pkg::ST_OK, sorted_value: '0, last_value: 1'b0};
      end
      cse_pkg::S_SCAN: begin
        if (rdata_q != '0) begin
          wr_en    = 1'b1;
          wr_addr  = pos_q;
          wr_data  = rdata_q - 1'b1;
          items_d  = items_q - 1'b1;
          cursor_d = pos_q;
          done_d   = 1'b1;
          rsp_d.status       = cse_pkg::ST_OK;
          rsp_d.sorted_value = {~pos_q[VB-1], pos_q[VB-2:0]};
          rsp_d.last_value   = (items_q == CB'(1));
          // The final value leaves every bin at zero already; only the
          // scan bounds go back to their empty-store values.
          if (items_q == CB'(1)) begin
            cursor_d  = '0;
            highest_d = '0;
          end
        end else if (pos_q >= highest_q) begin
          done_d = 1'b1;
          rsp_d  = '{status: cse_pkg::ST_EMPTY, sorted_value: '0, last_value: 1'b0};
        end else begin
          rd_en   = 1'b1;
          rd_addr = pos_q + 1'b1;
          pos_d   = pos_q + 1'b1;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cse_pkg::S_CLEAR;
      clr_q     <= '0;
      cursor_q  <= '0;
      highest_q <= '0;
      items_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cursor_q  <= cursor_d;
      highest_q <= highest_d;
      items_q   <= items_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    idx_q <= idx_d;
    rsp_q <= rsp_d;
  end

  assign busy_o = (state_q != cse_pkg::S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A result always closes its item, so the engine is free again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while the engine is still busy");

  a_empty_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (items_q == '0) |-> (cursor_q == '0 && highest_q == '0))
    else $error("empty store with scan bounds not at their empty values");

  a_last_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.last_value) |-> (items_q == '0 && rsp_o.status == cse_pkg::ST_OK))
    else $error("last value reported while values remain held");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != cse_pkg::ST_OK) |->
      (rsp_o.sorted_value == '0 && !rsp_o.last_value))
    else $error("refused or empty result carries a value");

endmodule
